### rtl/sidu_pkg.sv
// Shared types for the signed integer divider unit.
package sidu_pkg;

	// Status flags that travel with a quotient.
	typedef struct packed {
		logic div_by_zero;
		logic overflow;
	} sidu_flags_t;

endpackage

### rtl/signed_integer_divider_unit.sv
// One request at a time: req_stall is high from accept until the result moves to the output
//   register; a zero divisor skips the shift loop and goes straight to the fix state.
// The restoring shift loop settles one quotient bit per cycle through a single subtractor;
//   the fix state then applies the sign and saturation and waits for a free output register.
// The next request is taken while a finished response still waits in the output register.
// Reset (arst_n low, asynchronous): controller goes idle, no response valid.
module signed_integer_divider_unit
	import sidu_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic signed [DATA_WIDTH-1:0] dividend,
	input  logic signed [DATA_WIDTH-1:0] divisor,
	// response channel
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic signed [DATA_WIDTH-1:0] quotient,
	output logic                         div_by_zero,
	output logic                         overflow
);

	localparam int CNT_W = $clog2(DATA_WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;     // remaining quotient bits minus one
	logic [DATA_WIDTH-1:0]   rem_q;     // partial remainder, below |divisor| throughout the shift loop
	logic [DATA_WIDTH-1:0]   quo_q;     // dividend bits shift out, quotient bits shift in
	logic [DATA_WIDTH-1:0]   dsr_q;     // |divisor|
	logic                    neg_q;     // final result gets negated
	logic                    dbz_q;
	logic                    rsp_valid_q;
	logic [DATA_WIDTH-1:0]   quotient_q;
	sidu_flags_t             flags_q;

	logic                    req_accept;
	logic                    rsp_free;
	logic [DATA_WIDTH-1:0]   mag_a;
	logic [DATA_WIDTH-1:0]   mag_b;
	logic                    a_neg;
	logic                    b_neg;
	logic                    a_zero;
	logic                    b_zero;
	logic [DATA_WIDTH:0]     trial;
	logic [DATA_WIDTH-1:0]   fix_res;
	logic                    fix_ovf;

	assign req_stall  = (state_q != ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	// output register can take a new response this cycle
	assign rsp_free   = !rsp_valid_q || !rsp_stall;

	// operand magnitudes; the most negative value maps to 2^(W-1), which fits unsigned
	always_comb begin
		a_neg  = dividend[DATA_WIDTH-1];
		b_neg  = divisor[DATA_WIDTH-1];
		a_zero = (dividend == '0);
		b_zero = (divisor == '0);
		mag_a  = a_neg ? (~dividend + 1'b1) : dividend;
		mag_b  = b_neg ? (~divisor + 1'b1) : divisor;
	end

	// one restoring step: bring down the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[DATA_WIDTH-1]} - {1'b0, dsr_q};

	// sign fix and saturation: only a positive quotient of 2^(W-1) overflows
	always_comb begin
		fix_ovf = !neg_q && !dbz_q && quo_q[DATA_WIDTH-1];
		if (fix_ovf) begin
			fix_res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end else if (neg_q) begin
			fix_res = ~quo_q + 1'b1;
		end else begin
			fix_res = quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// load a finished result, else drop the one just taken
			if (state_q == ST_FIX && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_accept) begin
						cnt_q   <= CNT_W'(DATA_WIDTH - 1);
						// a zero divisor needs no loop: the result is -|dividend|
						state_q <= b_zero ? ST_FIX : ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (req_accept) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dsr_q <= mag_b;
			dbz_q <= b_zero;
			neg_q <= b_zero || a_zero || (a_neg != b_neg);
		end else if (state_q == ST_DIV) begin
			if (!trial[DATA_WIDTH]) begin
				rem_q <= trial[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DATA_WIDTH-2:0], quo_q[DATA_WIDTH-1]};
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
		if (state_q == ST_FIX && rsp_free) begin
			quotient_q          <= fix_res;
			flags_q.div_by_zero <= dbz_q;
			flags_q.overflow    <= fix_ovf;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign quotient    = quotient_q;
	assign div_by_zero = flags_q.div_by_zero;
	assign overflow    = flags_q.overflow;

	// a nonzero divisor always runs the shift loop
	assert property (@(posedge clk) disable iff (!arst_n)
		req_accept && !b_zero |=> state_q == ST_DIV)
		else $error("nonzero divisor did not enter the shift loop");

	// the loop leaves after its last bit
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && cnt_q == '0 |=> state_q == ST_FIX)
		else $error("shift loop did not end on its last bit");

	// the two flags exclude each other
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(flags_q.div_by_zero && flags_q.overflow))
		else $error("divide by zero and overflow both set");

	// overflow always comes with the saturated positive maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && flags_q.overflow |->
			quotient_q == {1'b0, {(DATA_WIDTH-1){1'b1}}})
		else $error("overflow without saturated quotient");

	// a response waiting under stall is not overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |=> rsp_valid_q && $stable(quotient_q))
		else $error("stalled response lost or changed");

endmodule

### tb/sidu_checker.sv
// Checker for the signed integer divider unit: predicts each quotient and compares responses.
`timescale 1ns / 100ps

module sidu_checker
	import sidu_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_stall,
	input  logic signed [DATA_WIDTH-1:0] dividend,
	input  logic signed [DATA_WIDTH-1:0] divisor,
	input  logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  logic signed [DATA_WIDTH-1:0] quotient,
	input  logic                         div_by_zero,
	input  logic                         overflow,
	output int                           fail_count,
	output int                           pending
);

	localparam logic [DATA_WIDTH-1:0] SAT_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	typedef struct packed {
		logic [DATA_WIDTH-1:0] dividend;
		logic [DATA_WIDTH-1:0] divisor;
		logic [DATA_WIDTH-1:0] quotient;
		sidu_flags_t           flags;
	} quot_rec_t;

	quot_rec_t quotients_due[$];
	int        mismatches;
	int        in_flight;

	assign fail_count = mismatches;
	assign pending    = in_flight;

	// Truncating signed division with saturation of MIN / -1; a zero divisor gives -|dividend|.
	function automatic quot_rec_t divide_model(logic [DATA_WIDTH-1:0] a,
			logic [DATA_WIDTH-1:0] b);
		logic [DATA_WIDTH-1:0] mag_a;
		logic [DATA_WIDTH-1:0] mag_b;
		logic [DATA_WIDTH-1:0] q;
		quot_rec_t             r;
		mag_a = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
		mag_b = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
		r.dividend          = a;
		r.divisor           = b;
		r.flags.div_by_zero = 1'b0;
		r.flags.overflow    = 1'b0;
		if (b == '0) begin
			r.flags.div_by_zero = 1'b1;
			r.quotient          = ~mag_a + 1'b1;
		end else begin
			q = mag_a / mag_b;
			if (a != '0 && a[DATA_WIDTH-1] == b[DATA_WIDTH-1]) begin
				if (q > SAT_POS) begin
					r.flags.overflow = 1'b1;
					q                = SAT_POS;
				end
				r.quotient = q;
			end else begin
				r.quotient = ~q + 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		quot_rec_t exp_rec;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (quotients_due.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("%0t: response with none outstanding: q=%0d dbz=%b ovf=%b",
							$time, quotient, div_by_zero, overflow);
				end else begin
					exp_rec = quotients_due.pop_front();
					if (quotient !== exp_rec.quotient
							|| div_by_zero !== exp_rec.flags.div_by_zero
							|| overflow !== exp_rec.flags.overflow) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("%0t: %0d / %0d expected q=%0d dbz=%b ovf=%b, got q=%0d dbz=%b ovf=%b",
								$time, $signed(exp_rec.dividend), $signed(exp_rec.divisor),
								$signed(exp_rec.quotient), exp_rec.flags.div_by_zero,
								exp_rec.flags.overflow, quotient, div_by_zero, overflow);
					end
				end
			end
			if (req_valid && !req_stall)
				quotients_due.push_back(divide_model(dividend, divisor));
			in_flight <= quotients_due.size();
		end
	end

endmodule

### tb/tb_signed_integer_divider_unit.sv
// Testbench top for the signed integer divider unit: stimulus, idling, timeout and verdict.
`timescale 1ns / 100ps

module tb_signed_integer_divider_unit;

	localparam int DW = 32;
	localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] NEG_ONE = {DW{1'b1}};
	localparam int N_RANDOM = 1400;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic signed [DW-1:0] dividend  = '0;
	logic signed [DW-1:0] divisor   = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic signed [DW-1:0] quotient;
	logic                 div_by_zero;
	logic                 overflow;

	int fail_count;
	int pending;

	// Burst phases: sender sends back to back, receiver never stalls.
	bit no_gaps  = 1'b0;
	bit rsp_calm = 1'b0;
	int stall_left = 0;

	signed_integer_divider_unit #(.DATA_WIDTH(DW)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.dividend   (dividend),
		.divisor    (divisor),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.quotient   (quotient),
		.div_by_zero(div_by_zero),
		.overflow   (overflow)
	);

	sidu_checker #(.DATA_WIDTH(DW)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.dividend   (dividend),
		.divisor    (divisor),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.quotient   (quotient),
		.div_by_zero(div_by_zero),
		.overflow   (overflow),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 8 ns clock
	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver back-pressure: mostly free, short stalls often, a long one now and then.
	// Evaluated every cycle so stalls land on every phase of the divide loop.
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (rsp_calm) begin
			rsp_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (r < 60) begin
			rsp_stall <= 1'b0;
		end else if (r < 92) begin
			rsp_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			rsp_stall  <= 1'b1;
			stall_left <= $urandom_range(5, 60);
		end
	end

	// Idle cycles before the next request: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 45)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 50);
	endfunction

	// Present one transaction and hold it until accepted. A zero gap keeps valid high,
	// so valid is never dropped and raised in the same step.
	task automatic send_div(logic [DW-1:0] a, logic [DW-1:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		dividend  <= a;
		divisor   <= b;
		do @(posedge clk); while (req_stall);
	endtask

	// Hold off the sender until every outstanding quotient has come back.
	// The first edge lets the count take in the transaction accepted just before.
	task automatic drain_quotients();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Operand with a spread of magnitudes: full range, shortened, small, and corner values.
	function automatic logic [DW-1:0] rand_operand();
		logic [DW-1:0] v;
		int            r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2, 3: begin
				v = $urandom;
			end
			4, 5, 6: begin
				v = $urandom >> $urandom_range(0, DW-1);
				if ($urandom_range(0, 1))
					v = ~v + 1'b1;
			end
			7: begin
				v = $urandom_range(0, 16);
				if ($urandom_range(0, 1))
					v = ~v + 1'b1;
			end
			8: begin
				case ($urandom_range(0, 4))
					0: v = MIN_VAL;
					1: v = MAX_VAL;
					2: v = '0;
					3: v = NEG_ONE;
					default: v = 1;
				endcase
			end
			default: begin
				v = $urandom >> $urandom_range(DW/2, DW-1);
			end
		endcase
		return v;
	endfunction

	initial begin
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		int            r;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: divide by zero with every kind of dividend
		send_div('0, '0);
		send_div(MIN_VAL, '0);
		send_div(MAX_VAL, '0);
		send_div(NEG_ONE, '0);
		send_div(37, '0);
		// most negative over minus one saturates
		send_div(MIN_VAL, NEG_ONE);
		send_div(MIN_VAL, 1);
		send_div(MIN_VAL, MIN_VAL);
		send_div(MAX_VAL, MAX_VAL);
		send_div(MAX_VAL, NEG_ONE);
		send_div(MAX_VAL, 1);
		send_div(MAX_VAL, MIN_VAL);
		send_div(MIN_VAL, MAX_VAL);
		send_div(MIN_VAL, 2);
		// zero dividend with nonzero divisor
		send_div('0, 5);
		send_div('0, -5);
		send_div('0, MIN_VAL);
		// truncation toward zero, all sign combinations
		send_div(7, 2);
		send_div(-7, 2);
		send_div(7, -2);
		send_div(-7, -2);
		send_div(1, MIN_VAL);
		send_div(NEG_ONE, NEG_ONE);
		send_div(5, 7);
		send_div(NEG_ONE, MIN_VAL);

		// Sender waits for the pipeline to empty before the random part.
		req_valid <= 1'b0;
		drain_quotients();

		for (int i = 0; i < N_RANDOM; i++) begin
			// Phase control: some stretches back to back with a free receiver.
			if (i % 200 == 0) begin
				no_gaps  = ($urandom_range(0, 2) == 0);
				rsp_calm = ($urandom_range(0, 2) == 0);
			end
			if (i == N_RANDOM / 2) begin
				req_valid <= 1'b0;
				drain_quotients();
			end
			r = $urandom_range(0, 99);
			if (r < 2) begin
				a = MIN_VAL;
				b = NEG_ONE;
			end else if (r < 6) begin
				a = rand_operand();
				b = '0;
			end else begin
				a = rand_operand();
				b = rand_operand();
			end
			send_div(a, b);
		end
		req_valid <= 1'b0;
		rsp_calm  = 1'b0;

		// Drain, then linger a full divide latency for any stray response.
		drain_quotients();
		repeat (DW + 8) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
